### rtl/core/blast_neighborhood_words_assert.svh
// Assertion macros shared by the neighborhood word generator.
`ifndef BLAST_NEIGHBORHOOD_WORDS_ASSERT_SVH
`define BLAST_NEIGHBORHOOD_WORDS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BNW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define BNW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bnw_pkg.sv
// Shared types and constants of the neighborhood word generator.
package bnw_pkg;

  localparam int ALPHABET_MAX_DEF = 32;
  localparam int MAX_WORD_DEF     = 4;
  localparam int POS_BITS_DEF     = 16;
  localparam int SCORE_BITS_DEF   = 8;

  localparam int THR_W      = 10;
  localparam int ALPHA_W    = 6;
  localparam int QLEN_W     = 3;
  localparam int CODE_W     = 20;
  localparam int SYM_W      = 5;
  localparam int MSCORE_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [THR_W-1:0]   THR_RST   = 10'd11;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 6'd20;
  localparam logic [QLEN_W-1:0]  QLEN_RST  = 3'd3;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHABET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LEN  = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_PUSH  = 2'd2,
    OP_PULL  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WALK,
    ST_WALK_ADD,
    ST_CODE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic scan_rd;
    logic scan_cmp;
    logic walk_step;
    logic walk_add;
    logic code_step;
    logic result;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic push_walk;
    logic walk_active;
    logic scan_done;
    logic walk_found;
    logic walk_exhausted;
    logic walk_read;
    logic code_last;
    logic out_free;
  } status_t;

endpackage

### rtl/core/blast_neighborhood_words.sv
// Top level of the BLAST neighborhood word generator.
// Requests enter on the in_ channel (valid/ready) and each one yields exactly one
// result on the out_ channel (valid/ready). Opcodes: load one score table entry,
// start a query, push a query residue, or pull the next neighborhood word.
// A load, a start, or a push that leaves no full window goes from decode
// straight to the result state. A push that completes a window scans the score
// table for each window row, alternating a read state and a compare state for
// each column through the single table read port. A pull resumes the pruned
// depth-first walk: each descent or sibling step reads the table and then
// adds the score, a pruned or backtracking step reads nothing, and a found
// word has its base-alphabet code built digit by digit before the result
// state; how long a pull takes thus varies with the data.
// One request is processed at a time; in_ready is high only while the
// sequencer is idle, so a new request can be accepted in the cycle after the
// previous result is registered. The result register lets the next request be
// accepted while a result still waits for out_ready; a further result then
// waits until the register frees up. Configuration writes (cfg_we) take
// effect at once and must be issued while the block is idle. Reset clears the
// query, the walk and the result register and restores the default threshold,
// alphabet size and word length; the score table holds no defined contents until it is loaded.
module blast_neighborhood_words #(
  parameter int ALPHABET_MAX = bnw_pkg::ALPHABET_MAX_DEF,
  parameter int MAX_WORD     = bnw_pkg::MAX_WORD_DEF,
  parameter int POS_BITS     = bnw_pkg::POS_BITS_DEF,
  parameter int SCORE_BITS   = bnw_pkg::SCORE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_opcode,
  input  logic [bnw_pkg::SYM_W-1:0]           in_matrix_row,
  input  logic [bnw_pkg::SYM_W-1:0]           in_matrix_col,
  input  logic signed [bnw_pkg::MSCORE_W-1:0] in_matrix_score,
  input  logic [bnw_pkg::SYM_W-1:0]           in_residue,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_word_valid,
  output logic [bnw_pkg::CODE_W-1:0]          out_word_code,
  output logic [POS_BITS-1:0]                 out_query_position,
  output logic                                out_window_done,
  input  logic                                cfg_we,
  input  logic [bnw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bnw_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  `include "blast_neighborhood_words_assert.svh"

  bnw_pkg::cmd_t    cmd;
  bnw_pkg::status_t sts;

  bnw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bnw_dpath #(
    .ALPHABET_MAX (ALPHABET_MAX),
    .MAX_WORD     (MAX_WORD),
    .POS_BITS     (POS_BITS),
    .SCORE_BITS   (SCORE_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_matrix_row      (in_matrix_row),
    .in_matrix_col      (in_matrix_col),
    .in_matrix_score    (in_matrix_score),
    .in_residue         (in_residue),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_word_valid     (out_word_valid),
    .out_word_code      (out_word_code),
    .out_query_position (out_query_position),
    .out_window_done    (out_window_done)
  );

  `BNW_ASSERT_SAME(a_word_not_done, out_valid && out_word_valid, !out_window_done,
                   "returned word flagged with an exhausted window")
  `BNW_ASSERT_SAME(a_no_word_zero_code, out_valid && !out_word_valid, out_word_code == '0,
                   "nonzero code without a word")
  `BNW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                   "request accepted while the previous one is in progress")

endmodule

### rtl/core/bnw_ram.sv
// Generic single-port RAM with registered read data.
module bnw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/bnw_ctrl.sv
// Sequencer that steps each request through decode, table scan, walk and code build.
module bnw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output bnw_pkg::cmd_t    cmd,
  input  bnw_pkg::status_t sts
);

  bnw_pkg::state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bnw_pkg::ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bnw_pkg::ST_IDLE: begin
        if (in_valid) st_nxt = bnw_pkg::ST_DECODE;
      end
      bnw_pkg::ST_DECODE: begin
        if (sts.op == bnw_pkg::OP_PUSH && sts.push_walk) begin
          st_nxt = bnw_pkg::ST_SCAN_RD;
        end else if (sts.op == bnw_pkg::OP_PULL && sts.walk_active) begin
          st_nxt = bnw_pkg::ST_WALK;
        end else begin
          st_nxt = bnw_pkg::ST_RESULT;
        end
      end
      bnw_pkg::ST_SCAN_RD:  st_nxt = bnw_pkg::ST_SCAN_CMP;
      bnw_pkg::ST_SCAN_CMP: st_nxt = sts.scan_done ? bnw_pkg::ST_RESULT : bnw_pkg::ST_SCAN_RD;
      bnw_pkg::ST_WALK: begin
        if (sts.walk_found) begin
          st_nxt = bnw_pkg::ST_CODE;
        end else if (sts.walk_exhausted) begin
          st_nxt = bnw_pkg::ST_RESULT;
        end else if (sts.walk_read) begin
          st_nxt = bnw_pkg::ST_WALK_ADD;
        end
      end
      bnw_pkg::ST_WALK_ADD: st_nxt = bnw_pkg::ST_WALK;
      bnw_pkg::ST_CODE: begin
        if (sts.code_last) st_nxt = bnw_pkg::ST_RESULT;
      end
      bnw_pkg::ST_RESULT: begin
        if (sts.out_free) st_nxt = bnw_pkg::ST_IDLE;
      end
      default: st_nxt = bnw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (st_r)
      bnw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      bnw_pkg::ST_DECODE:   cmd.execute   = 1'b1;
      bnw_pkg::ST_SCAN_RD:  cmd.scan_rd   = 1'b1;
      bnw_pkg::ST_SCAN_CMP: cmd.scan_cmp  = 1'b1;
      bnw_pkg::ST_WALK:     cmd.walk_step = 1'b1;
      bnw_pkg::ST_WALK_ADD: cmd.walk_add  = 1'b1;
      bnw_pkg::ST_CODE:     cmd.code_step = 1'b1;
      bnw_pkg::ST_RESULT:   cmd.result    = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/bnw_dpath.sv
// Datapath: score table, query window, walk registers, code builder and result register.
module bnw_dpath #(
  parameter int ALPHABET_MAX = bnw_pkg::ALPHABET_MAX_DEF,
  parameter int MAX_WORD     = bnw_pkg::MAX_WORD_DEF,
  parameter int POS_BITS     = bnw_pkg::POS_BITS_DEF,
  parameter int SCORE_BITS   = bnw_pkg::SCORE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bnw_pkg::cmd_t                       cmd,
  output bnw_pkg::status_t                    sts,
  input  logic [1:0]                          in_opcode,
  input  logic [bnw_pkg::SYM_W-1:0]           in_matrix_row,
  input  logic [bnw_pkg::SYM_W-1:0]           in_matrix_col,
  input  logic signed [bnw_pkg::MSCORE_W-1:0] in_matrix_score,
  input  logic [bnw_pkg::SYM_W-1:0]           in_residue,
  input  logic                                cfg_we,
  input  logic [bnw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bnw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_word_valid,
  output logic [bnw_pkg::CODE_W-1:0]          out_word_code,
  output logic [POS_BITS-1:0]                 out_query_position,
  output logic                                out_window_done
);

  localparam int RW    = $clog2(ALPHABET_MAX);
  localparam int AW    = $clog2(ALPHABET_MAX * ALPHABET_MAX);
  localparam int AL_W  = $clog2(ALPHABET_MAX + 1);
  localparam int Q_W   = $clog2(MAX_WORD + 1);
  localparam int IW    = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int ACC_W = (SCORE_BITS + 5 > 11) ? SCORE_BITS + 5 : 11;
  localparam logic signed [ACC_W-1:0] S_HI = ACC_W'((2 ** (SCORE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] S_LO = -S_HI - ACC_W'(1);

  // Configuration registers.
  logic [bnw_pkg::THR_W-1:0]   thr_r;
  logic [bnw_pkg::ALPHA_W-1:0] alpha_r;
  logic [bnw_pkg::QLEN_W-1:0]  qlen_r;

  // Captured request.
  bnw_pkg::op_t               op_r;
  logic [bnw_pkg::SYM_W-1:0]  mrow_r, mcol_r, res_r;
  logic [bnw_pkg::MSCORE_W-1:0] mscore_r;

  // Query and walk state.
  logic [bnw_pkg::SYM_W-1:0] window_r [MAX_WORD];
  logic [RW-1:0]             digit_r  [MAX_WORD];
  logic signed [ACC_W-1:0]   prefix_r [MAX_WORD+1];
  logic signed [ACC_W-1:0]   suffix_r [MAX_WORD];
  logic [POS_BITS-1:0]       count_r;
  logic                      active_r;
  logic                      enter_r;
  logic                      found_r;
  logic [Q_W-1:0]            d_r, add_r, sd_r, ci_r;
  logic [RW-1:0]             col_r;
  logic signed [SCORE_BITS-1:0] best_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic [bnw_pkg::CODE_W-1:0] code_r;

  // Result register.
  logic                       out_valid_r, out_wv_r, out_done_r;
  logic [bnw_pkg::CODE_W-1:0] out_code_r;
  logic [POS_BITS-1:0]        out_pos_r;

  // Effective configuration.
  logic [AL_W-1:0] a_eff;
  logic [Q_W-1:0]  q_eff;
  logic signed [ACC_W-1:0] thr_ext;

  always_comb begin
    if (alpha_r == '0) begin
      a_eff = AL_W'(1);
    end else if (7'(alpha_r) > 7'(ALPHABET_MAX)) begin
      a_eff = AL_W'(ALPHABET_MAX);
    end else begin
      a_eff = AL_W'(alpha_r);
    end
    if (qlen_r == '0) begin
      q_eff = Q_W'(1);
    end else if (5'(qlen_r) > 5'(MAX_WORD)) begin
      q_eff = Q_W'(MAX_WORD);
    end else begin
      q_eff = Q_W'(qlen_r);
    end
  end

  assign thr_ext = {{(ACC_W-bnw_pkg::THR_W){thr_r[bnw_pkg::THR_W-1]}}, thr_r};

  function automatic logic [RW-1:0] row_of(input logic [bnw_pkg::SYM_W-1:0] r);
    row_of = (7'(r) < 7'(ALPHABET_MAX)) ? RW'(r) : RW'(ALPHABET_MAX - 1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row, input logic [RW-1:0] col);
    addr_of = AW'(AW'(row) * AW'(ALPHABET_MAX)) + AW'(col);
  endfunction

  // Table row of window position d for the current word length.
  function automatic logic [RW-1:0] win_row(input logic [Q_W-1:0] d,
                                           input logic [Q_W-1:0] q);
    logic [Q_W:0] widx;
    widx = (Q_W+1)'(MAX_WORD) - (Q_W+1)'(q) + (Q_W+1)'(d);
    win_row = row_of(window_r[widx[IW-1:0]]);
  endfunction

  // Request decode helpers.
  logic [POS_BITS-1:0] count_inc;
  assign count_inc = (count_r == '1) ? count_r : count_r + POS_BITS'(1);

  logic signed [ACC_W-1:0] ms_ext, ms_clamp;
  assign ms_ext = {{(ACC_W-bnw_pkg::MSCORE_W){mscore_r[bnw_pkg::MSCORE_W-1]}}, mscore_r};
  assign ms_clamp = (ms_ext > S_HI) ? S_HI : ((ms_ext < S_LO) ? S_LO : ms_ext);

  logic load_ok;
  assign load_ok = (7'(mrow_r) < 7'(ALPHABET_MAX)) && (7'(mcol_r) < 7'(ALPHABET_MAX));

  // Table read data widened to the accumulator.
  logic [SCORE_BITS-1:0]   rdata;
  logic signed [ACC_W-1:0] rd_ext;
  assign rd_ext = {{(ACC_W-SCORE_BITS){rdata[SCORE_BITS-1]}}, rdata};

  // Row-maximum scan.
  logic                         last_col;
  logic signed [SCORE_BITS-1:0] best_n;
  logic signed [ACC_W-1:0]      acc_n;
  assign last_col = (AL_W'(col_r) + AL_W'(1)) == a_eff;
  assign best_n = (col_r == '0 || $signed(rdata) > best_r) ? $signed(rdata) : best_r;
  assign acc_n = acc_r + {{(ACC_W-SCORE_BITS){best_n[SCORE_BITS-1]}}, best_n};

  // Walk step decisions.
  logic           d_ge_q, bound_ok, inc_ok, hit;
  logic [Q_W-1:0] dm1;
  assign dm1      = d_r - Q_W'(1);
  assign d_ge_q   = d_r >= q_eff;
  assign bound_ok = (prefix_r[d_r] + suffix_r[d_r[IW-1:0]]) >= thr_ext;
  assign inc_ok   = (AL_W'(digit_r[dm1[IW-1:0]]) + AL_W'(1)) < a_eff;
  assign hit      = prefix_r[q_eff] >= thr_ext;

  // Table port: loads in decode, scans and walk steps read.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  always_comb begin
    ram_we   = cmd.execute && op_r == bnw_pkg::OP_LOAD && load_ok;
    ram_addr = addr_of(RW'(mrow_r), RW'(mcol_r));
    if (cmd.scan_rd) begin
      ram_addr = addr_of(win_row(sd_r, q_eff), col_r);
    end else if (cmd.walk_step) begin
      if (enter_r) begin
        ram_addr = addr_of(win_row(d_r, q_eff), '0);
      end else begin
        ram_addr = addr_of(win_row(dm1, q_eff), digit_r[dm1[IW-1:0]] + RW'(1));
      end
    end
  end

  bnw_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (ALPHABET_MAX * ALPHABET_MAX)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ms_clamp[SCORE_BITS-1:0]),
    .rdata (rdata)
  );

  // Payload registers of the captured request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= bnw_pkg::op_t'(in_opcode);
      mrow_r   <= in_matrix_row;
      mcol_r   <= in_matrix_col;
      mscore_r <= in_matrix_score;
      res_r    <= in_residue;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= bnw_pkg::THR_RST;
      alpha_r  <= bnw_pkg::ALPHA_RST;
      qlen_r   <= bnw_pkg::QLEN_RST;
      count_r  <= '0;
      active_r <= 1'b0;
      enter_r  <= 1'b0;
      found_r  <= 1'b0;
      d_r      <= '0;
      add_r    <= '0;
      sd_r     <= '0;
      ci_r     <= '0;
      col_r    <= '0;
      best_r   <= '0;
      acc_r    <= '0;
      code_r   <= '0;
      for (int i = 0; i < MAX_WORD; i++) begin
        window_r[i] <= '0;
        digit_r[i]  <= '0;
        suffix_r[i] <= '0;
      end
      for (int i = 0; i <= MAX_WORD; i++) begin
        prefix_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bnw_pkg::REG_THRESHOLD: thr_r <= cfg_wdata[bnw_pkg::THR_W-1:0];
          bnw_pkg::REG_ALPHABET: begin
            alpha_r  <= cfg_wdata[bnw_pkg::ALPHA_W-1:0];
            active_r <= 1'b0;
          end
          bnw_pkg::REG_WORD_LEN: begin
            qlen_r   <= cfg_wdata[bnw_pkg::QLEN_W-1:0];
            active_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.capture) begin
        found_r <= 1'b0;
      end

      if (cmd.execute) begin
        case (op_r)
          bnw_pkg::OP_START: begin
            count_r  <= '0;
            active_r <= 1'b0;
            d_r      <= '0;
            for (int i = 0; i < MAX_WORD; i++) begin
              window_r[i] <= '0;
            end
          end
          bnw_pkg::OP_PUSH: begin
            for (int i = 0; i < MAX_WORD - 1; i++) begin
              window_r[i] <= window_r[i+1];
            end
            window_r[MAX_WORD-1] <= res_r;
            count_r <= count_inc;
            sd_r    <= q_eff - Q_W'(1);
            col_r   <= '0;
            acc_r   <= '0;
          end
          bnw_pkg::OP_PULL: begin
            enter_r <= d_r < q_eff;
          end
          default: ;
        endcase
      end

      // The window is scanned from its last symbol back, so the suffix bounds
      // accumulate as each row maximum completes.
      if (cmd.scan_cmp) begin
        best_r <= best_n;
        if (last_col) begin
          acc_r <= acc_n;
          suffix_r[sd_r[IW-1:0]] <= acc_n;
          if (sd_r == '0) begin
            prefix_r[0] <= '0;
            d_r         <= '0;
            active_r    <= 1'b1;
          end else begin
            sd_r  <= sd_r - Q_W'(1);
            col_r <= '0;
          end
        end else begin
          col_r <= col_r + RW'(1);
        end
      end

      if (cmd.walk_step) begin
        if (enter_r) begin
          if (d_ge_q) begin
            if (hit) begin
              found_r <= 1'b1;
              code_r  <= '0;
              ci_r    <= '0;
            end else begin
              enter_r <= 1'b0;
            end
          end else if (bound_ok) begin
            digit_r[d_r[IW-1:0]] <= '0;
            add_r <= d_r;
          end else begin
            enter_r <= 1'b0;
          end
        end else if (d_r == '0) begin
          active_r <= 1'b0;
        end else begin
          d_r <= dm1;
          if (inc_ok) begin
            digit_r[dm1[IW-1:0]] <= digit_r[dm1[IW-1:0]] + RW'(1);
            add_r   <= dm1;
            enter_r <= 1'b1;
          end
        end
      end

      if (cmd.walk_add) begin
        prefix_r[add_r + Q_W'(1)] <= prefix_r[add_r] + rd_ext;
        d_r <= add_r + Q_W'(1);
      end

      if (cmd.code_step) begin
        code_r <= bnw_pkg::CODE_W'(code_r * bnw_pkg::CODE_W'(a_eff))
                  + bnw_pkg::CODE_W'(digit_r[ci_r[IW-1:0]]);
        ci_r   <= ci_r + Q_W'(1);
      end
    end
  end

  // Result register.
  logic [POS_BITS-1:0] pos;
  assign pos = (count_r >= POS_BITS'(q_eff)) ? count_r - POS_BITS'(q_eff) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result) begin
      out_wv_r   <= found_r;
      out_code_r <= found_r ? code_r : '0;
      out_pos_r  <= pos;
      out_done_r <= !active_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_word_valid     = out_wv_r;
  assign out_word_code      = out_code_r;
  assign out_query_position = out_pos_r;
  assign out_window_done    = out_done_r;

  always_comb begin
    sts                = '0;
    sts.op             = op_r;
    sts.push_walk      = count_inc >= POS_BITS'(q_eff);
    sts.walk_active    = active_r;
    sts.scan_done      = last_col && sd_r == '0;
    sts.walk_found     = enter_r && d_ge_q && hit;
    sts.walk_exhausted = !enter_r && d_r == '0;
    sts.walk_read      = enter_r ? (!d_ge_q && bound_ok) : (d_r != '0 && inc_ok);
    sts.code_last      = ci_r == q_eff - Q_W'(1);
    sts.out_free       = !out_valid_r || out_ready;
  end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the neighborhood word generator with its own predictor.
module testbench;

  localparam logic [bnw_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TBL_DIM = 32;
  localparam int WORD_MAX = 4;

  typedef struct {
    bnw_pkg::op_t      op;
    logic [4:0]        row;
    logic [4:0]        col;
    logic signed [7:0] score;
    logic [4:0]        residue;
  } request_t;

  typedef struct {
    logic        word_valid;
    logic [19:0] word_code;
    logic [15:0] position;
    logic        done;
  } word_result_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_opcode;
  logic [4:0] in_matrix_row, in_matrix_col, in_residue;
  logic signed [7:0] in_matrix_score;
  logic out_word_valid, out_window_done;
  logic [19:0] out_word_code;
  logic [15:0] out_query_position;
  logic cfg_we;
  logic [bnw_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bnw_pkg::CFG_DATA_W-1:0] cfg_wdata;

  blast_neighborhood_words dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_matrix_row(in_matrix_row), .in_matrix_col(in_matrix_col),
    .in_matrix_score(in_matrix_score), .in_residue(in_residue),
    .out_valid(out_valid), .out_ready(out_ready), .out_word_valid(out_word_valid),
    .out_word_code(out_word_code), .out_query_position(out_query_position),
    .out_window_done(out_window_done),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  request_t pending_q[$];
  word_result_t expected_words[$];
  int mismatches = 0;
  int cycles = 0;
  bit no_idle = 0;
  int send_gap = 0;
  int recv_stall = 0;

  // Predictor state.
  int score_tbl[TBL_DIM*TBL_DIM];
  int best_in_row[TBL_DIM];
  int window_syms[WORD_MAX];
  int digits[WORD_MAX];
  int prefix[WORD_MAX+1];
  int suffix[WORD_MAX];
  int depth, residues_seen;
  bit walking;
  int threshold, alpha_reg, qlen_reg;

  function automatic int eff_alpha();
    return alpha_reg < 1 ? 1 : (alpha_reg > TBL_DIM ? TBL_DIM : alpha_reg);
  endfunction

  function automatic int eff_qlen();
    return qlen_reg < 1 ? 1 : (qlen_reg > WORD_MAX ? WORD_MAX : qlen_reg);
  endfunction

  function automatic int window_row(int d);
    return window_syms[WORD_MAX - eff_qlen() + d];
  endfunction

  // Residues are drawn from the rows that the table load covers.
  function automatic int pick_residue();
    int r;
    r = $urandom_range(0, 7);
    return r < 4 ? r : r + 24;
  endfunction

  function automatic void begin_walk();
    int q, a, r, best, acc;
    q = eff_qlen();
    a = eff_alpha();
    for (int d = 0; d < q; d++) begin
      r = window_row(d);
      best = score_tbl[r*TBL_DIM];
      for (int c = 1; c < a; c++)
        if (score_tbl[r*TBL_DIM + c] > best) best = score_tbl[r*TBL_DIM + c];
      best_in_row[r] = best;
    end
    acc = 0;
    for (int d = q; d > 0; d--) begin
      acc += best_in_row[window_row(d-1)];
      suffix[d-1] = acc;
    end
    prefix[0] = 0;
    depth = 0;
    walking = 1;
  endfunction

  // Resume the pruned depth-first walk; returns 1 when a word qualifies.
  function automatic bit next_word();
    int q, a, d;
    bit enter;
    q = eff_qlen();
    a = eff_alpha();
    d = depth > q ? q : depth;
    enter = d < q;
    forever begin
      if (enter) begin
        if (d >= q) begin
          if (prefix[q] >= threshold) begin
            depth = d;
            return 1;
          end
          enter = 0;
        end else if (prefix[d] + suffix[d] >= threshold) begin
          digits[d] = 0;
          prefix[d+1] = prefix[d] + score_tbl[window_row(d)*TBL_DIM];
          d++;
        end else begin
          enter = 0;
        end
      end else begin
        if (d == 0) begin
          walking = 0;
          depth = 0;
          return 0;
        end
        d--;
        if (digits[d] + 1 < a) begin
          digits[d]++;
          prefix[d+1] = prefix[d] + score_tbl[window_row(d)*TBL_DIM + digits[d]];
          d++;
          enter = 1;
        end
      end
    end
  endfunction

  function automatic word_result_t predict_word(request_t rq);
    word_result_t res;
    int q, code;
    res.word_valid = 0;
    code = 0;
    case (rq.op)
      bnw_pkg::OP_LOAD: score_tbl[rq.row*TBL_DIM + rq.col] = int'(rq.score);
      bnw_pkg::OP_START: begin
        residues_seen = 0;
        for (int i = 0; i < WORD_MAX; i++) window_syms[i] = 0;
        walking = 0;
        depth = 0;
      end
      bnw_pkg::OP_PUSH: begin
        for (int i = 0; i < WORD_MAX-1; i++) window_syms[i] = window_syms[i+1];
        window_syms[WORD_MAX-1] = rq.residue;
        if (residues_seen < 65535) residues_seen++;
        if (residues_seen >= eff_qlen()) begin_walk();
      end
      default: begin
        if (walking && next_word()) begin
          res.word_valid = 1;
          for (int d = 0; d < eff_qlen(); d++) code = code * eff_alpha() + digits[d];
        end
      end
    endcase
    q = eff_qlen();
    res.word_code = code[19:0];
    res.position = residues_seen >= q ? 16'(residues_seen - q) : 16'd0;
    res.done = !walking;
    return res;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Request driver.
  always @(posedge clk) begin
    request_t rq;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_ready) begin
      in_valid <= 1;
    end else begin
      if (in_valid) begin
        rq.op = bnw_pkg::op_t'(in_opcode);
        rq.row = in_matrix_row;
        rq.col = in_matrix_col;
        rq.score = in_matrix_score;
        rq.residue = in_residue;
        expected_words.push_back(predict_word(rq));
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (!no_idle && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 0;
      end else if (pending_q.size() > 0) begin
        rq = pending_q.pop_front();
        in_valid <= 1;
        in_opcode <= rq.op;
        in_matrix_row <= rq.row;
        in_matrix_col <= rq.col;
        in_matrix_score <= rq.score;
        in_residue <= rq.residue;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    word_result_t exp_w;
    cycles++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result code=%0h", out_word_code);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_word_valid !== exp_w.word_valid || out_word_code !== exp_w.word_code ||
            out_query_position !== exp_w.position || out_window_done !== exp_w.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected v=%0b code=%0h pos=%0d done=%0b, ",
                      "got v=%0b code=%0h pos=%0d done=%0b"},
                     exp_w.word_valid, exp_w.word_code, exp_w.position, exp_w.done,
                     out_word_valid, out_word_code, out_query_position, out_window_done);
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 0;
    end else if (!no_idle && $urandom_range(0, 5) == 0) begin
      recv_stall = $urandom_range(0, 6);
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("blast_neighborhood_words regression: fail");
      $finish;
    end
  end

  task automatic add_req(bnw_pkg::op_t op, int row, int col, int score, int residue);
    request_t rq;
    rq.op = op;
    rq.row = row[4:0];
    rq.col = col[4:0];
    rq.score = score[7:0];
    rq.residue = residue[4:0];
    pending_q.push_back(rq);
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_words.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [bnw_pkg::CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= value[bnw_pkg::CFG_DATA_W-1:0];
    if (idx == bnw_pkg::REG_THRESHOLD) begin
      threshold = value[9] ? int'(value[9:0]) - 1024 : int'(value[9:0]);
    end else if (idx == bnw_pkg::REG_ALPHABET) begin
      alpha_reg = value & 63;
      walking = 0;
    end else if (idx == bnw_pkg::REG_WORD_LEN) begin
      qlen_reg = value & 7;
      walking = 0;
    end
  endtask

  task automatic configure(int thr, int alpha, int qlen);
    write_reg(bnw_pkg::REG_THRESHOLD, thr);
    write_reg(bnw_pkg::REG_ALPHABET, alpha);
    write_reg(bnw_pkg::REG_WORD_LEN, qlen);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Mostly well-formed queries: start, then pushes, each followed by a run of pulls.
  task automatic random_phase(int count);
    int n, sel;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        add_req(bnw_pkg::OP_START, $urandom, $urandom, $urandom, pick_residue());
        n++;
        repeat ($urandom_range(1, 6)) begin
          add_req(bnw_pkg::OP_PUSH, $urandom, $urandom, $urandom, pick_residue());
          n++;
          repeat ($urandom_range(0, 5)) begin
            add_req(bnw_pkg::OP_PULL, $urandom, $urandom, $urandom, pick_residue());
            n++;
          end
        end
      end else begin
        add_req(bnw_pkg::op_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                pick_residue());
        n++;
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_opcode = bnw_pkg::OP_LOAD;
    in_matrix_row = 0;
    in_matrix_col = 0;
    in_matrix_score = 0;
    in_residue = 0;
    out_ready = 0;
    cfg_we = 0;
    cfg_index = bnw_pkg::REG_THRESHOLD;
    cfg_wdata = 0;
    for (int i = 0; i < TBL_DIM*TBL_DIM; i++) score_tbl[i] = 0;
    for (int i = 0; i < TBL_DIM; i++) best_in_row[i] = 0;
    for (int i = 0; i < WORD_MAX; i++) begin
      window_syms[i] = 0;
      digits[i] = 0;
      suffix[i] = 0;
    end
    for (int i = 0; i <= WORD_MAX; i++) prefix[i] = 0;
    depth = 0;
    residues_seen = 0;
    walking = 0;
    threshold = 11;
    alpha_reg = 20;
    qlen_reg = 3;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // Every row that a pushed residue can select is loaded in full first, so no
    // walk ever reads an unwritten entry.
    for (int i = 0; i < 8; i++)
      for (int c = 0; c < TBL_DIM; c++)
        add_req(bnw_pkg::OP_LOAD, i < 4 ? i : i + 24, c, $urandom_range(0, 255), 0);

    // Directed: pulls before any query, score extremes, window edges.
    add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 31);
    add_req(bnw_pkg::OP_LOAD, 31, 31, 127, 0);
    add_req(bnw_pkg::OP_LOAD, 0, 31, -128, 0);
    add_req(bnw_pkg::OP_LOAD, 31, 0, -128, 0);
    add_req(bnw_pkg::OP_START, 31, 31, -1, 31);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 31);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_PULL, 31, 31, 127, 31);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 29);
    add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 3);
    add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_START, 0, 0, 0, 0);
    add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    drain();

    // An index beyond the register list is ignored.
    write_reg(REG_SPARE, 1023);
    @(posedge clk);
    cfg_we <= 0;

    configure(5, 3, 4);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 1);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 2);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 30);
    add_req(bnw_pkg::OP_PUSH, 0, 0, 0, 31);
    // Keep pulling until this small window runs dry.
    repeat (200) add_req(bnw_pkg::OP_PULL, 0, 0, 0, 0);
    random_phase(120);
    drain();
    configure(-512, 32, 4);
    random_phase(120);
    drain();
    configure(511, 32, 2);
    random_phase(120);
    drain();
    configure(0, 0, 0);
    random_phase(120);
    drain();
    configure(-20, 63, 7);
    random_phase(120);
    drain();
    configure(30, 7, 5);
    random_phase(120);
    drain();
    configure(-1, 3, 1);
    random_phase(120);
    drain();
    configure(100, 8, 3);
    random_phase(120);
    drain();
    configure(-300 + $urandom_range(0, 40), 2, 6);
    random_phase(120);
    drain();

    // Final stretch without idling.
    no_idle = 1;
    configure(-512, 32, 4);
    random_phase(100);
    drain();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("blast_neighborhood_words regression: pass");
    end else begin
      $display("blast_neighborhood_words regression: fail");
    end
    $finish;
  end

endmodule
